// ----- rtl/bgc_pkg.sv -----
// ---------------------------------------------------------------------------
// bgc_pkg
// Shared types and constants of the button gesture classifier.
// ---------------------------------------------------------------------------
`default_nettype none

package bgc_pkg;

   localparam int COUNTER_BITS = 16;
   localparam int CFG_BITS     = 16;
   localparam int CSR_IDX_BITS = 2;
   localparam int EVENT_BITS   = 2;

   // compare width that holds both a count and a threshold
   localparam int CMP_BITS = (COUNTER_BITS > CFG_BITS) ? COUNTER_BITS : CFG_BITS;

   localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = CFG_BITS'(200);
   localparam logic [CFG_BITS-1:0] DOUBLE_GAP_RESET = CFG_BITS'(87);
   localparam logic [CFG_BITS-1:0] MIN_PRESS_RESET  = CFG_BITS'(2);

   typedef enum logic [EVENT_BITS-1:0] {
      EV_NONE   = 2'd0,
      EV_CLICK  = 2'd1,
      EV_DOUBLE = 2'd2,
      EV_LONG   = 2'd3
   } event_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_LONG_PRESS = 2'd0,
      CSR_DOUBLE_GAP = 2'd1,
      CSR_MIN_PRESS  = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   typedef logic [COUNTER_BITS-1:0] count_type;

endpackage

`default_nettype wire

// ----- rtl/button_gesture_classifier_top.sv -----
// ---------------------------------------------------------------------------
// button_gesture_classifier_top
// Click, double click and long press detector for an active-low button.
// ---------------------------------------------------------------------------
//
// Usage:
//   Each request on the req_ channel is one sampling tick of the button pin
//   (req_button_level: 0 pressed, 1 released). Every request yields exactly
//   one response on the rsp_ channel carrying rsp_gesture_event
//   (none, click, double click, long press).
//   Response: registered, valid in the cycle after the request is accepted.
//   Throughput: one request per cycle while req_stall is low; the phase update and both counter
//   updates are one short pass of logic between the state registers and
//   the response register.
//   Stall: the response register holds while rsp_stall is high; a new
//   request is taken in the same cycle as the held response leaves, and
//   req_stall rises only while a response is held and stalled.
//   Configuration: csr_ writes are always ready; index 0 sets the long press
//   threshold, 1 the double click window, 2 the minimum press length, and
//   index 3 is ignored. Write only while the block is idle.
//   Reset: synchronous, active high; clears the phase to idle, both counters
//   to zero, the thresholds to 200, 87 and 2, and drops any held response.
//
`default_nettype none

module button_gesture_classifier_top (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire                            req_button_level,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic [bgc_pkg::EVENT_BITS-1:0] rsp_gesture_event,
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire [bgc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire [bgc_pkg::CFG_BITS-1:0]    csr_wdata
);
   import bgc_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE       = 2'd0,
      PH_PRESS      = 2'd1,
      PH_WAIT_CLICK = 2'd2,
      PH_WAIT_REL   = 2'd3
   } phase_type;

   localparam count_type COUNT_ONE = count_type'(1);
   localparam count_type COUNT_MAX = '1;

   // configuration registers
   logic [CFG_BITS-1:0] long_press_ff, double_gap_ff, min_press_ff;

   // gesture state
   phase_type phase_ff, phase_in;
   count_type press_count_ff, press_count_in;
   count_type gap_count_ff, gap_count_in;

   // response register
   logic      rsp_valid_ff, rsp_valid_in;
   event_type rsp_event_ff, rsp_event_in;

   logic      req_take;
   logic      pressed;
   count_type press_inc, gap_inc;

   assign csr_ready = 1'b1;

   // hold the request side only while a response waits and is stalled
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   assign pressed   = !req_button_level;

   // saturating increments, the counters never wrap
   assign press_inc = (press_count_ff == COUNT_MAX) ? COUNT_MAX : press_count_ff + COUNT_ONE;
   assign gap_inc   = (gap_count_ff == COUNT_MAX) ? COUNT_MAX : gap_count_ff + COUNT_ONE;

   // next gesture state and event for one tick
   always_comb begin
      phase_in       = phase_ff;
      press_count_in = press_count_ff;
      gap_count_in   = gap_count_ff;
      rsp_event_in   = EV_NONE;
      unique case (phase_ff)
         PH_IDLE: begin
            if (pressed) begin
               press_count_in = COUNT_ONE;
               phase_in       = PH_PRESS;
            end
         end
         PH_PRESS: begin
            if (pressed) begin
               press_count_in = press_inc;
               if (CMP_BITS'(press_inc) >= CMP_BITS'(long_press_ff)) begin
                  phase_in     = PH_IDLE;
                  rsp_event_in = EV_LONG;
               end
            end else if (CMP_BITS'(press_count_ff) >= CMP_BITS'(min_press_ff)) begin
               gap_count_in = COUNT_ONE;
               phase_in     = PH_WAIT_CLICK;
            end else begin
               // too short: drop the press
               phase_in = PH_IDLE;
            end
         end
         PH_WAIT_CLICK: begin
            if (pressed) begin
               press_count_in = COUNT_ONE;
               phase_in       = PH_WAIT_REL;
            end else begin
               gap_count_in = gap_inc;
               if (CMP_BITS'(gap_inc) >= CMP_BITS'(double_gap_ff)) begin
                  phase_in     = PH_IDLE;
                  rsp_event_in = EV_CLICK;
               end
            end
         end
         PH_WAIT_REL: begin
            // no timeout on the second release
            if (!pressed) begin
               phase_in     = PH_IDLE;
               rsp_event_in = EV_DOUBLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // response valid: load on a taken request, clear once delivered
   always_comb begin
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         press_count_ff <= '0;
         gap_count_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
         long_press_ff  <= LONG_PRESS_RESET;
         double_gap_ff  <= DOUBLE_GAP_RESET;
         min_press_ff   <= MIN_PRESS_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         // advance the state only on a taken request
         if (req_take) begin
            phase_ff       <= phase_in;
            press_count_ff <= press_count_in;
            gap_count_ff   <= gap_count_in;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_LONG_PRESS: long_press_ff <= csr_wdata;
               CSR_DOUBLE_GAP: double_gap_ff <= csr_wdata;
               CSR_MIN_PRESS:  min_press_ff  <= csr_wdata;
               CSR_UNUSED:     ;
               default:        ;
            endcase
         end
      end
   end

   // response payload needs no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_event_ff <= rsp_event_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_gesture_event = rsp_event_ff;

endmodule

`default_nettype wire

// ----- rtl/bgc_checker.sv -----
// ---------------------------------------------------------------------------
// bgc_checker
// Port-level checks of the button gesture classifier, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

module bgc_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_valid,
   input wire                             req_stall,
   input wire                             rsp_valid,
   input wire                             rsp_stall,
   input wire [bgc_pkg::EVENT_BITS-1:0]   rsp_gesture_event
);
   import bgc_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_gesture_event))
      else $error("stalled response changed");

   // reset drops any response
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stall the request side only while a response is held
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held response");

   // every taken request yields a response next cycle
   a_req_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("taken request gave no response");

endmodule

bind button_gesture_classifier_top bgc_checker u_bgc_checker (.*);

`default_nettype wire
